// ===== rtl/core/ugns_pkg.sv =====
// Shared types, constants and helper functions of the uniform-grid neighbor search.
package ugns_pkg;

   localparam int MAX_AGENTS = 64;
   localparam int ID_W       = $clog2(MAX_AGENTS);
   localparam int SLOT_W     = $clog2(MAX_AGENTS + 1);
   localparam int CNT_W      = $clog2(MAX_AGENTS + 1);
   localparam int MAX_GRID   = 16;
   localparam int GRID_W     = 5;
   localparam int COORD_W    = 16;
   localparam int CELL_W     = 8;
   localparam int RECIP_W    = 17;
   localparam int PROD_W     = CELL_W + RECIP_W;
   localparam int NCELL_W    = 9;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_MOVE  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_ROWS   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_COLS   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CELL_WIDTH  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CELL_HEIGHT = 2'd3;

   localparam logic [GRID_W-1:0]  RST_GRID_ROWS   = 5'd10;
   localparam logic [GRID_W-1:0]  RST_GRID_COLS   = 5'd10;
   localparam logic [COORD_W-1:0] RST_CELL_WIDTH  = 16'd6400;
   localparam logic [COORD_W-1:0] RST_CELL_HEIGHT = 16'd6400;

   // grid geometry as the cell logic sees it (rows/cols already clamped)
   typedef struct packed {
      logic [GRID_W-1:0]  rows;
      logic [GRID_W-1:0]  cols;
      logic [COORD_W-1:0] cell_w;
      logic [COORD_W-1:0] cell_h;
   } grid_cfg_type;

   typedef struct packed {
      logic [CELL_W-1:0]  grid_cell;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } slot_type;

   localparam int SLOT_DATA_W = $bits(slot_type);

   function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] v);
      logic [GRID_W-1:0] r;
      r = v;
      if (v == '0) r = GRID_W'(1);
      else if (v > GRID_W'(MAX_GRID)) r = GRID_W'(MAX_GRID);
      return r;
   endfunction

   // ceil(2^16 / cols); (c * recip) >> 16 equals c / cols for any 8-bit c
   function automatic logic [RECIP_W-1:0] recip(input logic [GRID_W-1:0] cols);
      logic [RECIP_W-1:0] r;
      case (cols)
         5'd1:    r = 17'd65536;
         5'd2:    r = 17'd32768;
         5'd3:    r = 17'd21846;
         5'd4:    r = 17'd16384;
         5'd5:    r = 17'd13108;
         5'd6:    r = 17'd10923;
         5'd7:    r = 17'd9363;
         5'd8:    r = 17'd8192;
         5'd9:    r = 17'd7282;
         5'd10:   r = 17'd6554;
         5'd11:   r = 17'd5958;
         5'd12:   r = 17'd5462;
         5'd13:   r = 17'd5042;
         5'd14:   r = 17'd4682;
         5'd15:   r = 17'd4370;
         5'd16:   r = 17'd4096;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/uniform_grid_neighbor_search.sv =====
// Top level of the uniform-grid fixed-radius neighbor search.
// One item is handled at a time; req_tready is high only while the block is idle,
// but a finished result may still sit in the output register waiting for rsp_tready.
// Add and move compute the grid cell with two bit-serial dividers (16 steps); a
// move of an absent agent and an unknown kind skip the dividers and go straight
// to ST_DONE to answer. A query computes its own cell the same way, splits it into
// row and column (states ST_QDIV and ST_QREM), then streams all 64 agent slots out
// of the slot RAM, one read per cycle while the output register can take a result,
// through a 4-stage compare pipeline. Each matching slot gives one transfer in
// slot order; the last transfer of every item carries rsp_tlast. A query with
// no match, an add and a move each give exactly one transfer with found clear.
// Slot positions and cells live in one 64x40 RAM; the present flags sit in
// flip-flops that reset clears, so no clearing pass is needed after reset.
// Configuration is written through csr_* and must only change while idle.
module uniform_grid_neighbor_search
   import ugns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,  // agent_id, pos_x, pos_y, radius, zero pad
   input  logic [1:0]            req_tuser,  // kind
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,  // neighbor_id, found, match_count, status, pad
   output logic                  rsp_tlast
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CELL  = 3'd1;
   localparam logic [2:0] ST_QDIV  = 3'd2;
   localparam logic [2:0] ST_QREM  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam int R2_W = 2 * COORD_W;

   // ---------------- configuration ----------------
   logic [GRID_W-1:0]  rows_ff, cols_ff;
   logic [COORD_W-1:0] cell_w_ff, cell_h_ff;
   grid_cfg_type       gcfg;
   logic [NCELL_W-1:0] ncells;
   logic [RECIP_W-1:0] cols_recip;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= RST_GRID_ROWS;
         cols_ff   <= RST_GRID_COLS;
         cell_w_ff <= RST_CELL_WIDTH;
         cell_h_ff <= RST_CELL_HEIGHT;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_GRID_ROWS:   rows_ff   <= csr_wdata[GRID_W-1:0];
            CSR_GRID_COLS:   cols_ff   <= csr_wdata[GRID_W-1:0];
            CSR_CELL_WIDTH:  cell_w_ff <= csr_wdata;
            CSR_CELL_HEIGHT: cell_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign gcfg.rows   = clamp_grid(rows_ff);
   assign gcfg.cols   = clamp_grid(cols_ff);
   assign gcfg.cell_w = cell_w_ff;
   assign gcfg.cell_h = cell_h_ff;
   assign ncells      = NCELL_W'(gcfg.rows) * NCELL_W'(gcfg.cols);
   assign cols_recip  = recip(gcfg.cols);

   // ---------------- request fields ----------------
   logic [ID_W-1:0]    req_id;
   logic [COORD_W-1:0] req_x, req_y, req_rad;
   logic               req_fire;

   assign req_id   = req_tdata[5:0];
   assign req_x    = req_tdata[21:6];
   assign req_y    = req_tdata[37:22];
   assign req_rad  = req_tdata[53:38];
   assign req_fire = req_tvalid & req_tready;

   // ---------------- state ----------------
   logic [2:0]            state_ff, state_in;
   logic [1:0]            kind_ff, kind_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [COORD_W-1:0]    qx_ff, qx_in, qy_ff, qy_in, rad_ff, rad_in;
   logic                  status_ff, status_in;
   logic [MAX_AGENTS-1:0] present_ff, present_in;

   logic [CELL_W-1:0]     qcell_ff, qcell_in;
   logic [PROD_W-1:0]     qprod_ff, qprod_in;
   logic [CELL_W-1:0]     qr_ff, qr_in, qc_ff, qc_in;
   logic [R2_W-1:0]       r2_ff, r2_in;

   logic [SLOT_W-1:0]     issue_ff, issue_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  held_vld_ff, held_vld_in;
   logic [ID_W-1:0]       held_slot_ff, held_slot_in;

   // compare pipeline
   logic                  s1_vld_ff, s1_vld_in, s1_pres_ff, s1_pres_in;
   logic [ID_W-1:0]       s1_slot_ff, s1_slot_in;
   logic                  s2_vld_ff, s2_vld_in, s2_ok_ff, s2_ok_in;
   logic [ID_W-1:0]       s2_slot_ff, s2_slot_in;
   logic [PROD_W-1:0]     s2_prod_ff, s2_prod_in;
   logic [CELL_W-1:0]     s2_cell_ff, s2_cell_in;
   logic [COORD_W-1:0]    s2_x_ff, s2_x_in, s2_y_ff, s2_y_in;
   logic                  s3_vld_ff, s3_vld_in, s3_ok_ff, s3_ok_in;
   logic [ID_W-1:0]       s3_slot_ff, s3_slot_in;
   logic [COORD_W-1:0]    s3_dx_ff, s3_dx_in, s3_dy_ff, s3_dy_in;
   logic                  s4_vld_ff, s4_vld_in, s4_ok_ff, s4_ok_in;
   logic [ID_W-1:0]       s4_slot_ff, s4_slot_in;
   logic [R2_W-1:0]       s4_dx2_ff, s4_dx2_in, s4_dy2_ff, s4_dy2_in;

   // output register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]      rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   // cell unit and slot RAM
   logic                  cell_start, cell_done;
   logic [CELL_W-1:0]     cell_idx;
   logic                  ram_wr_en, ram_rd_en;
   slot_type              ram_wdata, ram_rdata;
   logic [ID_W-1:0]       ram_rd_addr;

   // helpers
   logic                  out_free, adv, s4_match;
   logic [R2_W:0]         dist2;
   logic [CELL_W-1:0]     s2_cr, s2_cc, q_cr;
   logic                  row_near, col_near;

   ugns_cell u_cell (
      .clock    (clock),
      .reset    (reset),
      .start    (cell_start),
      .pos_x    (req_x),
      .pos_y    (req_y),
      .cfg      (gcfg),
      .done     (cell_done),
      .cell_num (cell_idx)
   );

   ugns_ram #(
      .WIDTH (SLOT_DATA_W),
      .DEPTH (MAX_AGENTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (id_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

   assign ram_wdata.grid_cell = cell_idx;
   assign ram_wdata.y         = qy_ff;
   assign ram_wdata.x         = qx_ff;
   assign ram_rd_addr         = issue_ff[ID_W-1:0];

   assign out_free   = ~rsp_vld_ff | rsp_tready;
   assign adv        = out_free;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      // defaults: hold
      state_in     = state_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rad_in       = rad_ff;
      status_in    = status_ff;
      present_in   = present_ff;
      qcell_in     = qcell_ff;
      qprod_in     = qprod_ff;
      qr_in        = qr_ff;
      qc_in        = qc_ff;
      r2_in        = r2_ff;
      issue_in     = issue_ff;
      count_in     = count_ff;
      held_vld_in  = held_vld_ff;
      held_slot_in = held_slot_ff;
      s1_vld_in = s1_vld_ff;  s1_pres_in = s1_pres_ff;  s1_slot_in = s1_slot_ff;
      s2_vld_in = s2_vld_ff;  s2_ok_in = s2_ok_ff;      s2_slot_in = s2_slot_ff;
      s2_prod_in = s2_prod_ff; s2_cell_in = s2_cell_ff;
      s2_x_in = s2_x_ff;      s2_y_in = s2_y_ff;
      s3_vld_in = s3_vld_ff;  s3_ok_in = s3_ok_ff;      s3_slot_in = s3_slot_ff;
      s3_dx_in = s3_dx_ff;    s3_dy_in = s3_dy_ff;
      s4_vld_in = s4_vld_ff;  s4_ok_in = s4_ok_ff;      s4_slot_in = s4_slot_ff;
      s4_dx2_in = s4_dx2_ff;  s4_dy2_in = s4_dy2_ff;
      rsp_vld_in    = rsp_vld_ff & ~rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      cell_start    = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      // pipeline datapath terms
      dist2    = {1'b0, s4_dx2_ff} + {1'b0, s4_dy2_ff};
      s4_match = s4_vld_ff & s4_ok_ff & (dist2 <= {1'b0, r2_ff});
      s2_cr    = s2_prod_ff[PROD_W-2:PROD_W-1-CELL_W];
      s2_cc    = s2_cell_ff - CELL_W'(s2_cr * CELL_W'(gcfg.cols));
      row_near = (s2_cr == qr_ff) || ({1'b0, s2_cr} == {1'b0, qr_ff} + 9'd1)
                 || ({1'b0, qr_ff} == {1'b0, s2_cr} + 9'd1);
      col_near = (s2_cc == qc_ff) || ({1'b0, s2_cc} == {1'b0, qc_ff} + 9'd1)
                 || ({1'b0, qc_ff} == {1'b0, s2_cc} + 9'd1);
      q_cr     = qprod_ff[PROD_W-2:PROD_W-1-CELL_W];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in   = req_tuser;
               id_in     = req_id;
               qx_in     = req_x;
               qy_in     = req_y;
               rad_in    = req_rad;
               status_in = 1'b0;
               case (req_tuser)
                  KIND_ADD, KIND_QUERY: begin
                     cell_start = 1'b1;
                     state_in   = ST_CELL;
                  end
                  KIND_MOVE: begin
                     if (present_ff[req_id]) begin
                        cell_start = 1'b1;
                        state_in   = ST_CELL;
                     end else begin
                        status_in = 1'b1;
                        state_in  = ST_DONE;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         ST_CELL: begin
            if (cell_done) begin
               if (kind_ff == KIND_QUERY) begin
                  qcell_in = cell_idx;
                  state_in = ST_QDIV;
               end else begin
                  ram_wr_en         = 1'b1;
                  present_in[id_ff] = 1'b1;
                  state_in          = ST_DONE;
               end
            end
         end

         ST_QDIV: begin
            qprod_in = PROD_W'(qcell_ff) * PROD_W'(cols_recip);
            r2_in    = R2_W'(rad_ff) * R2_W'(rad_ff);
            state_in = ST_QREM;
         end

         ST_QREM: begin
            qr_in       = q_cr;
            qc_in       = qcell_ff - CELL_W'(q_cr * CELL_W'(gcfg.cols));
            issue_in    = '0;
            count_in    = '0;
            held_vld_in = 1'b0;
            s1_vld_in   = 1'b0;
            s2_vld_in   = 1'b0;
            s3_vld_in   = 1'b0;
            s4_vld_in   = 1'b0;
            state_in    = ST_SCAN;
         end

         ST_SCAN: begin
            if (adv) begin
               // issue a slot read
               s1_vld_in = 1'b0;
               if (issue_ff != SLOT_W'(MAX_AGENTS)) begin
                  ram_rd_en  = 1'b1;
                  s1_vld_in  = 1'b1;
                  s1_slot_in = issue_ff[ID_W-1:0];
                  s1_pres_in = present_ff[issue_ff[ID_W-1:0]];
                  issue_in   = issue_ff + SLOT_W'(1);
               end
               // cell quotient by reciprocal
               s2_vld_in  = s1_vld_ff;
               s2_slot_in = s1_slot_ff;
               s2_ok_in   = s1_pres_ff & ({1'b0, ram_rdata.grid_cell} < ncells);
               s2_prod_in = PROD_W'(ram_rdata.grid_cell) * PROD_W'(cols_recip);
               s2_cell_in = ram_rdata.grid_cell;
               s2_x_in    = ram_rdata.x;
               s2_y_in    = ram_rdata.y;
               // neighborhood test and distances
               s3_vld_in  = s2_vld_ff;
               s3_slot_in = s2_slot_ff;
               s3_ok_in   = s2_ok_ff & row_near & col_near;
               s3_dx_in   = (s2_x_ff > qx_ff) ? s2_x_ff - qx_ff : qx_ff - s2_x_ff;
               s3_dy_in   = (s2_y_ff > qy_ff) ? s2_y_ff - qy_ff : qy_ff - s2_y_ff;
               // squares
               s4_vld_in  = s3_vld_ff;
               s4_slot_in = s3_slot_ff;
               s4_ok_in   = s3_ok_ff;
               s4_dx2_in  = R2_W'(s3_dx_ff) * R2_W'(s3_dx_ff);
               s4_dy2_in  = R2_W'(s3_dy_ff) * R2_W'(s3_dy_ff);
               // a match is held back one place so the final one can carry last
               if (s4_match) begin
                  if (held_vld_ff) begin
                     rsp_vld_in    = 1'b1;
                     rsp_id_in     = held_slot_ff;
                     rsp_found_in  = 1'b1;
                     rsp_cnt_in    = count_ff;
                     rsp_status_in = 1'b0;
                     rsp_last_in   = 1'b0;
                  end
                  held_vld_in  = 1'b1;
                  held_slot_in = s4_slot_ff;
                  count_in     = count_ff + CNT_W'(1);
               end
            end
            if (issue_ff == SLOT_W'(MAX_AGENTS) && !s1_vld_ff && !s2_vld_ff
                && !s3_vld_ff && !s4_vld_ff) begin
               state_in = ST_FLUSH;
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               rsp_vld_in    = 1'b1;
               rsp_id_in     = held_vld_ff ? held_slot_ff : '0;
               rsp_found_in  = held_vld_ff;
               rsp_cnt_in    = count_ff;
               rsp_status_in = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in    = 1'b1;
               rsp_id_in     = '0;
               rsp_found_in  = 1'b0;
               rsp_cnt_in    = '0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         present_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
         held_vld_ff <= 1'b0;
         issue_ff    <= '0;
         count_ff    <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
         s4_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         present_ff  <= present_in;
         rsp_vld_ff  <= rsp_vld_in;
         held_vld_ff <= held_vld_in;
         issue_ff    <= issue_in;
         count_ff    <= count_in;
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
         s3_vld_ff   <= s3_vld_in;
         s4_vld_ff   <= s4_vld_in;
      end
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      rad_ff        <= rad_in;
      status_ff     <= status_in;
      qcell_ff      <= qcell_in;
      qprod_ff      <= qprod_in;
      qr_ff         <= qr_in;
      qc_ff         <= qc_in;
      r2_ff         <= r2_in;
      held_slot_ff  <= held_slot_in;
      s1_pres_ff    <= s1_pres_in;
      s1_slot_ff    <= s1_slot_in;
      s2_ok_ff      <= s2_ok_in;
      s2_slot_ff    <= s2_slot_in;
      s2_prod_ff    <= s2_prod_in;
      s2_cell_ff    <= s2_cell_in;
      s2_x_ff       <= s2_x_in;
      s2_y_ff       <= s2_y_in;
      s3_ok_ff      <= s3_ok_in;
      s3_slot_ff    <= s3_slot_in;
      s3_dx_ff      <= s3_dx_in;
      s3_dy_ff      <= s3_dy_in;
      s4_ok_ff      <= s4_ok_in;
      s4_slot_ff    <= s4_slot_in;
      s4_dx2_ff     <= s4_dx2_in;
      s4_dy2_ff     <= s4_dy2_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_status_ff, rsp_cnt_ff, rsp_found_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/ugns_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ugns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ugns_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ugns_div
   import ugns_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COORD_W-1:0] dividend,
   input  logic [COORD_W-1:0] divisor,
   output logic               done,
   output logic [COORD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(COORD_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [COORD_W-1:0] quo_ff, quo_in;
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [COORD_W-1:0] div_ff, div_in;
   logic [COORD_W:0]   rem_sh;
   logic               ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[COORD_W-1]};
      ge      = rem_sh >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[COORD_W-2:0], ge};
         rem_in = ge ? COORD_W'(rem_sh - {1'b0, div_ff}) : rem_sh[COORD_W-1:0];
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(COORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/ugns_cell.sv =====
// Grid cell index of a point: two coordinate dividers and the row/col combine.
module ugns_cell
   import ugns_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COORD_W-1:0] pos_x,
   input  logic [COORD_W-1:0] pos_y,
   input  grid_cfg_type       cfg,
   output logic               done,
   output logic [CELL_W-1:0]  cell_num
);

   localparam int IDX_W = COORD_W + GRID_W + 1;

   logic [COORD_W-1:0] num_x, num_y, den_x, den_y;
   logic               done_x, done_y;
   logic [COORD_W-1:0] col_q, row_q;
   logic [IDX_W-1:0]   idx;
   logic [NCELL_W-1:0] ncells;
   logic [CELL_W-1:0]  top;
   logic               done_ff;
   logic [CELL_W-1:0]  cell_ff, cell_in;

   // whole cell sizes strictly exceeded: (c-1)/size, zero at c=0; size 0 acts as 1
   assign num_x = (pos_x == '0) ? '0 : pos_x - COORD_W'(1);
   assign num_y = (pos_y == '0) ? '0 : pos_y - COORD_W'(1);
   assign den_x = (cfg.cell_w == '0) ? COORD_W'(1) : cfg.cell_w;
   assign den_y = (cfg.cell_h == '0) ? COORD_W'(1) : cfg.cell_h;

   ugns_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (num_x),
      .divisor  (den_x),
      .done     (done_x),
      .quotient (col_q)
   );

   ugns_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (num_y),
      .divisor  (den_y),
      .done     (done_y),
      .quotient (row_q)
   );

   always_comb begin
      idx    = IDX_W'(row_q) * IDX_W'(cfg.cols) + IDX_W'(col_q);
      ncells = NCELL_W'(cfg.rows) * NCELL_W'(cfg.cols);
      top    = CELL_W'(ncells - NCELL_W'(1));
      cell_in = (idx > IDX_W'(top)) ? top : idx[CELL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_x & done_y;
      end
      cell_ff <= cell_in;
   end

   assign done     = done_ff;
   assign cell_num = cell_ff;

endmodule
